[src/rmc_pkg.sv]
// ============================================================================
// rmc_pkg: shared types and constants for the region mean color core
// Field widths, configuration register indexes and the per-frame job record
// that travels from the accumulating front end to the divider back end.
// ============================================================================
package rmc_pkg;

    // Field and state widths
    localparam int unsigned POS_W    = 12;
    localparam int unsigned LEN_W    = 13;
    localparam int unsigned PIXEL_W  = 24;
    localparam int unsigned COLOR_W  = 8;
    localparam int unsigned SUM_W    = 32;
    localparam int unsigned COUNT_W  = 25;
    localparam int unsigned CHANNELS = 3;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = LEN_W;

    // Channel slots inside a job
    localparam int unsigned CH_RED   = 0;
    localparam int unsigned CH_GREEN = 1;
    localparam int unsigned CH_BLUE  = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT   = 2'd0,
        CFG_TOP    = 2'd1,
        CFG_WIDTH  = 2'd2,
        CFG_HEIGHT = 2'd3
    } t_cfg_index;

    typedef logic [CHANNELS-1:0][SUM_W-1:0] t_sums;

    // Totals of one finished frame, handed to the divider
    typedef struct packed {
        t_sums              sums;
        logic [COUNT_W-1:0] count;
    } t_frame_job;

endpackage

[src/rmc_front.sv]
// ============================================================================
// rmc_front: pixel intake and region accumulation
// Holds the rectangle registers, tests each pixel against the rectangle and
// keeps the running channel sums and count. The last pixel of a frame pushes
// the frame totals into the job queue and clears the accumulators.
// ============================================================================
module rmc_front #(
    parameter int unsigned MAX_DIMENSION = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration writes
    input  logic                             i_cfg_we,
    input  logic [rmc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rmc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Pixel channel
    input  logic                             i_pixel_valid,
    output logic                             o_pixel_ready,
    input  logic [rmc_pkg::PIXEL_W-1:0]      i_pixel,
    input  logic [rmc_pkg::POS_W-1:0]        i_column,
    input  logic [rmc_pkg::POS_W-1:0]        i_row,
    input  logic                             i_end_of_frame,
    // Job queue write side
    input  logic                             i_push_ready,
    output logic                             o_push_valid,
    output rmc_pkg::t_frame_job              o_push_job
);

    localparam logic [rmc_pkg::LEN_W-1:0] MaxPos = rmc_pkg::LEN_W'(MAX_DIMENSION);

    logic [rmc_pkg::POS_W-1:0]   r_left;
    logic [rmc_pkg::POS_W-1:0]   r_top;
    logic [rmc_pkg::LEN_W-1:0]   r_width;
    logic [rmc_pkg::LEN_W-1:0]   r_height;
    rmc_pkg::t_sums              r_sums;
    logic [rmc_pkg::COUNT_W-1:0] r_count;
    rmc_pkg::t_sums              n_sums;
    logic [rmc_pkg::COUNT_W-1:0] n_count;

    logic [rmc_pkg::POS_W-1:0] col_off;
    logic [rmc_pkg::POS_W-1:0] row_off;
    logic                      col_in;
    logic                      row_in;
    logic                      in_rect;
    logic                      accept;

    // The queue only fills on frame ends, so a full queue stalls intake.
    assign o_pixel_ready = i_push_ready;
    assign accept        = i_pixel_valid && o_pixel_ready;

    // Rectangle test: left <= column < left + width and column < MAX_DIMENSION, same for rows.
    assign col_off = i_column - r_left;
    assign row_off = i_row - r_top;
    assign col_in  = ({1'b0, i_column} < MaxPos) && (i_column >= r_left)
                     && ({1'b0, col_off} < r_width);
    assign row_in  = ({1'b0, i_row} < MaxPos) && (i_row >= r_top)
                     && ({1'b0, row_off} < r_height);
    assign in_rect = col_in && row_in;

    // Sums including the current pixel.
    always_comb begin
        n_sums  = r_sums;
        n_count = r_count;
        if (in_rect) begin
            n_sums[rmc_pkg::CH_RED]   = r_sums[rmc_pkg::CH_RED]
                + rmc_pkg::SUM_W'(i_pixel[3*rmc_pkg::COLOR_W-1:2*rmc_pkg::COLOR_W]);
            n_sums[rmc_pkg::CH_GREEN] = r_sums[rmc_pkg::CH_GREEN]
                + rmc_pkg::SUM_W'(i_pixel[2*rmc_pkg::COLOR_W-1:rmc_pkg::COLOR_W]);
            n_sums[rmc_pkg::CH_BLUE]  = r_sums[rmc_pkg::CH_BLUE]
                + rmc_pkg::SUM_W'(i_pixel[rmc_pkg::COLOR_W-1:0]);
            n_count = r_count + rmc_pkg::COUNT_W'(1);
        end
    end

    assign o_push_valid     = accept && i_end_of_frame;
    assign o_push_job.sums  = n_sums;
    assign o_push_job.count = n_count;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_top    <= '0;
            r_width  <= rmc_pkg::LEN_W'(1);
            r_height <= rmc_pkg::LEN_W'(1);
        end else if (i_cfg_we) begin
            case (rmc_pkg::t_cfg_index'(i_cfg_index))
                rmc_pkg::CFG_LEFT:   r_left   <= i_cfg_data[rmc_pkg::POS_W-1:0];
                rmc_pkg::CFG_TOP:    r_top    <= i_cfg_data[rmc_pkg::POS_W-1:0];
                rmc_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                rmc_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Accumulators, cleared after the frame end item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sums  <= '0;
            r_count <= '0;
        end else if (accept) begin
            if (i_end_of_frame) begin
                r_sums  <= '0;
                r_count <= '0;
            end else begin
                r_sums  <= n_sums;
                r_count <= n_count;
            end
        end
    end

endmodule

[src/rmc_frame_queue.sv]
// ============================================================================
// rmc_frame_queue: two-entry queue of frame jobs
// Decouples the pixel intake from the divider so that either side can stall
// without holding up the other, until both entries hold jobs.
// ============================================================================
module rmc_frame_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rmc_pkg::t_frame_job i_push_job,
    output logic                o_push_ready,
    input  logic                i_pop,
    output logic                o_pop_valid,
    output rmc_pkg::t_frame_job o_pop_job
);

    rmc_pkg::t_frame_job r_mem [2];
    logic                r_wr_ptr;
    logic                r_rd_ptr;
    logic [1:0]          r_fill;
    logic                do_push;
    logic                do_pop;

    assign o_push_ready = (r_fill != 2'd2);
    assign o_pop_valid  = (r_fill != 2'd0);
    assign o_pop_job    = r_mem[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    // Storage entries.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

endmodule

[src/rmc_divider.sv]
// ============================================================================
// rmc_divider: mean computation back end
// Takes one frame job at a time and divides the three channel sums by the
// pixel count with a restoring divider, one quotient bit per cycle for all
// three channels at once, then presents the means on a registered output.
// ============================================================================
module rmc_divider (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Job queue read side
    input  logic                            i_job_valid,
    input  rmc_pkg::t_frame_job             i_job,
    output logic                            o_job_pop,
    // Result channel
    output logic                            o_mean_valid,
    input  logic                            i_mean_ready,
    output logic [rmc_pkg::COLOR_W-1:0]     o_mean_red,
    output logic [rmc_pkg::COLOR_W-1:0]     o_mean_green,
    output logic [rmc_pkg::COLOR_W-1:0]     o_mean_blue
);

    localparam int unsigned StepW = $clog2(rmc_pkg::SUM_W);
    localparam logic [StepW-1:0] LastStep = StepW'(rmc_pkg::SUM_W - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } t_state;

    t_state                      r_state;
    logic [StepW-1:0]            r_step;
    logic [rmc_pkg::COUNT_W-1:0] r_divisor;
    logic                        r_zero;
    logic [rmc_pkg::SUM_W-1:0]   r_dividend [rmc_pkg::CHANNELS];
    logic [rmc_pkg::COUNT_W-1:0] r_rem      [rmc_pkg::CHANNELS];
    logic [rmc_pkg::COLOR_W-1:0] r_quot     [rmc_pkg::CHANNELS];
    logic [rmc_pkg::COUNT_W-1:0] n_rem      [rmc_pkg::CHANNELS];
    logic [rmc_pkg::COLOR_W-1:0] n_quot     [rmc_pkg::CHANNELS];
    logic [rmc_pkg::COUNT_W:0]   rem_shift  [rmc_pkg::CHANNELS];
    logic [rmc_pkg::COUNT_W+1:0] rem_diff   [rmc_pkg::CHANNELS];
    logic                        r_out_valid;
    logic [rmc_pkg::COLOR_W-1:0] r_out      [rmc_pkg::CHANNELS];
    logic                        out_free;

    assign out_free  = !r_out_valid || i_mean_ready;
    assign o_job_pop = (r_state == ST_IDLE) && i_job_valid;

    assign o_mean_valid = r_out_valid;
    assign o_mean_red   = r_out[rmc_pkg::CH_RED];
    assign o_mean_green = r_out[rmc_pkg::CH_GREEN];
    assign o_mean_blue  = r_out[rmc_pkg::CH_BLUE];

    // One restoring division step per channel; only the low quotient byte is kept.
    always_comb begin
        for (int c = 0; c < rmc_pkg::CHANNELS; c++) begin
            rem_shift[c] = {r_rem[c], r_dividend[c][rmc_pkg::SUM_W-1]};
            rem_diff[c]  = {1'b0, rem_shift[c]} - (rmc_pkg::COUNT_W+2)'(r_divisor);
            if (!rem_diff[c][rmc_pkg::COUNT_W+1]) begin
                n_rem[c]  = rem_diff[c][rmc_pkg::COUNT_W-1:0];
                n_quot[c] = {r_quot[c][rmc_pkg::COLOR_W-2:0], 1'b1};
            end else begin
                n_rem[c]  = rem_shift[c][rmc_pkg::COUNT_W-1:0];
                n_quot[c] = {r_quot[c][rmc_pkg::COLOR_W-2:0], 1'b0};
            end
        end
    end

    // Sequencer, divider registers and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_mean_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        for (int c = 0; c < rmc_pkg::CHANNELS; c++) begin
                            r_dividend[c] <= i_job.sums[c];
                            r_rem[c]      <= '0;
                            r_quot[c]     <= '0;
                        end
                        r_divisor <= i_job.count;
                        r_zero    <= (i_job.count == '0);
                        r_step    <= '0;
                        r_state   <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    for (int c = 0; c < rmc_pkg::CHANNELS; c++) begin
                        r_dividend[c] <= {r_dividend[c][rmc_pkg::SUM_W-2:0], 1'b0};
                        r_rem[c]      <= n_rem[c];
                        r_quot[c]     <= n_quot[c];
                    end
                    r_step <= r_step + StepW'(1);
                    if (r_step == LastStep) begin
                        r_state <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (out_free) begin
                        for (int c = 0; c < rmc_pkg::CHANNELS; c++) begin
                            r_out[c] <= r_zero ? '0 : r_quot[c];
                        end
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[src/region_mean_color_core.sv]
// ============================================================================
// region_mean_color_core: mean color of a rectangle in a streamed frame
// Accumulates the pixels that fall inside the configured rectangle and, on
// the last pixel of each frame, emits the truncated mean red, green and blue.
// ============================================================================
// Pixels are taken one per cycle; intake stalls only while two finished
// frames wait in the job queue.
// A frame end item's totals go into the job queue, the divider loads them from
// the queue, runs its bit-serial division and then registers the output. The
// divider takes the next frame job only after the previous result is registered.
// Synchronous active-low reset clears the rectangle to a 1x1 box at the
// origin, the sums, the count, the queue and the output valid.
module region_mean_color_core #(
    parameter int unsigned MAX_DIMENSION = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration writes
    input  logic                            i_cfg_we,
    input  logic [rmc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rmc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Pixel channel
    input  logic                            i_pixel_valid,
    output logic                            o_pixel_ready,
    input  logic [rmc_pkg::PIXEL_W-1:0]     i_pixel,
    input  logic [rmc_pkg::POS_W-1:0]       i_column,
    input  logic [rmc_pkg::POS_W-1:0]       i_row,
    input  logic                            i_end_of_frame,
    // Result channel
    output logic                            o_mean_valid,
    input  logic                            i_mean_ready,
    output logic [rmc_pkg::COLOR_W-1:0]     o_mean_red,
    output logic [rmc_pkg::COLOR_W-1:0]     o_mean_green,
    output logic [rmc_pkg::COLOR_W-1:0]     o_mean_blue
);

    logic                push_valid;
    logic                push_ready;
    rmc_pkg::t_frame_job push_job;
    logic                pop_valid;
    logic                pop;
    rmc_pkg::t_frame_job pop_job;

    // Intake and accumulation.
    rmc_front #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_pixel_valid  (i_pixel_valid),
        .o_pixel_ready  (o_pixel_ready),
        .i_pixel        (i_pixel),
        .i_column       (i_column),
        .i_row          (i_row),
        .i_end_of_frame (i_end_of_frame),
        .i_push_ready   (push_ready),
        .o_push_valid   (push_valid),
        .o_push_job     (push_job)
    );

    // Frame job queue.
    rmc_frame_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push_valid),
        .i_push_job   (push_job),
        .o_push_ready (push_ready),
        .i_pop        (pop),
        .o_pop_valid  (pop_valid),
        .o_pop_job    (pop_job)
    );

    // Division and result output.
    rmc_divider u_divider (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (pop_valid),
        .i_job        (pop_job),
        .o_job_pop    (pop),
        .o_mean_valid (o_mean_valid),
        .i_mean_ready (i_mean_ready),
        .o_mean_red   (o_mean_red),
        .o_mean_green (o_mean_green),
        .o_mean_blue  (o_mean_blue)
    );

endmodule
